FILE: rtl/bspu_pkg.sv
// ----------------------------------------------------------------------------
// bspu_pkg
// Shared types, constants and bit permutation helpers for the bitfield,
// shift and permute unit.
// ----------------------------------------------------------------------------
package bspu_pkg;

	// default depth of the internal transaction queues
	localparam int unsigned QUEUE_DEPTH = 2;

	// byte swap masks for rev16
	localparam logic [63:0] HALF_SWAP_HI = 64'hFF00_FF00_FF00_FF00;
	localparam logic [63:0] HALF_SWAP_LO = 64'h00FF_00FF_00FF_00FF;
	localparam logic [63:0] LOW_WORD     = 64'h0000_0000_FFFF_FFFF;

	// byte masks for rev32
	localparam logic [63:0] REV32_M3 = 64'hFF00_0000_FF00_0000;
	localparam logic [63:0] REV32_M2 = 64'h00FF_0000_00FF_0000;
	localparam logic [63:0] REV32_M1 = 64'h0000_FF00_0000_FF00;
	localparam logic [63:0] REV32_M0 = 64'h0000_00FF_0000_00FF;

	// operation codes on the func port
	typedef enum logic [3:0] {
		FN_BFM   = 4'd0,
		FN_UBFM  = 4'd1,
		FN_SBFM  = 4'd2,
		FN_EXTR  = 4'd3,
		FN_ROR   = 4'd4,
		FN_LSLV  = 4'd5,
		FN_LSRV  = 4'd6,
		FN_ASRV  = 4'd7,
		FN_CLZ   = 4'd8,
		FN_RBIT  = 4'd9,
		FN_REV   = 4'd10,
		FN_REV16 = 4'd11,
		FN_REV32 = 4'd12
	} fn_t;

	// operation class handed from front to back
	typedef enum logic [3:0] {
		CL_BFM   = 4'd0,
		CL_UBFM  = 4'd1,
		CL_SBFM  = 4'd2,
		CL_SHIFT = 4'd3,
		CL_CLZ   = 4'd4,
		CL_RBIT  = 4'd5,
		CL_REV   = 4'd6,
		CL_REV16 = 4'd7,
		CL_REV32 = 4'd8,
		CL_ZERO  = 4'd9
	} cls_t;

	// decoded operation, one queue entry
	typedef struct packed {
		cls_t        cls;
		logic        wide;
		logic        sign;
		logic [6:0]  sh;
		logic [63:0] a;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [63:0] wm;
		logic [63:0] tm;
	} dec_t;

	// leading zeros of one byte, 8 when zero
	function automatic logic [3:0] clz8(input logic [7:0] x);
		logic [3:0] n;
		n = 4'd8;
		for (int i = 0; i < 8; i++) begin
			if (x[i]) begin
				n = 4'(7 - i);
			end
		end
		return n;
	endfunction

	// leading zeros of a 64-bit word, 64 when zero
	function automatic logic [6:0] clz64(input logic [63:0] x);
		logic [6:0] n;
		n = 7'd64;
		for (int j = 0; j < 8; j++) begin
			if (|x[8*j +: 8]) begin
				n = 7'(8 * (7 - j)) + {3'b000, clz8(x[8*j +: 8])};
			end
		end
		return n;
	endfunction

	// bit reversal of a 64-bit word
	function automatic logic [63:0] rev_bits64(input logic [63:0] x);
		logic [63:0] y;
		for (int i = 0; i < 64; i++) begin
			y[63 - i] = x[i];
		end
		return y;
	endfunction

	// byte reversal of a 64-bit word
	function automatic logic [63:0] bswap64(input logic [63:0] x);
		logic [63:0] y;
		for (int i = 0; i < 8; i++) begin
			y[8*(7 - i) +: 8] = x[8*i +: 8];
		end
		return y;
	endfunction

endpackage

FILE: rtl/bspu_queue.sv
// ----------------------------------------------------------------------------
// bspu_queue
// Small register based fifo with push/full and pop/empty handshakes;
// push and pop may both happen in one cycle.
// ----------------------------------------------------------------------------
module bspu_queue #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [IW-1:0]    wr_ptr_q;
	logic [IW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push_ok;
	logic             pop_ok;

	// handshake status
	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == IW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == IW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// payload storage
	always_ff @(posedge clk) begin
		if (push_ok) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

FILE: rtl/bspu_front.sv
// ----------------------------------------------------------------------------
// bspu_front
// Operation decode: classifies func, trims operands to the datasize and
// builds the funnel shifter operands, shift amount and bitfield masks.
// ----------------------------------------------------------------------------
module bspu_front (
	input  logic             [3:0]  func,
	input  logic                    wide,
	input  logic             [63:0] src_a,
	input  logic             [63:0] src_b,
	input  logic             [5:0]  rotate_field,
	input  logic             [5:0]  top_field,
	output bspu_pkg::dec_t          dec
);

	logic [5:0]  lv;
	logic [63:0] szm;
	logic [63:0] a_m;
	logic [63:0] b_m;
	logic [5:0]  s;
	logic [5:0]  r;
	logic [5:0]  d;
	logic [5:0]  amt;
	logic [63:0] ones_s;
	logic [63:0] ones_dbl;
	logic [127:0] ones_rot;
	logic [63:0] fx;
	logic [63:0] fy;
	bspu_pkg::cls_t cls;
	logic [6:0]  sh;

	// datasize trimming
	assign lv  = wide ? 6'd63 : 6'd31;
	assign szm = wide ? {64{1'b1}} : bspu_pkg::LOW_WORD;
	assign a_m = src_a & szm;
	assign b_m = src_b & szm;

	// immediates and amounts taken modulo the datasize
	assign s   = top_field & lv;
	assign r   = rotate_field & lv;
	assign d   = (s - r) & lv;
	assign amt = b_m[5:0] & lv;

	// wrap mask: s+1 ones rotated right by r within the datasize
	assign ones_s   = ~({64{1'b1}} << ({1'b0, s} + 7'd1));
	assign ones_dbl = wide ? ones_s : {ones_s[31:0], ones_s[31:0]};
	assign ones_rot = {ones_dbl, ones_dbl} >> r;

	// classify and pick funnel operands: result = ({x, y} >> sh) within size
	always_comb begin
		cls = bspu_pkg::CL_ZERO;
		sh  = {1'b0, amt};
		fx  = '0;
		fy  = '0;
		case (bspu_pkg::fn_t'(func))
			bspu_pkg::FN_BFM, bspu_pkg::FN_UBFM, bspu_pkg::FN_SBFM: begin
				cls = (bspu_pkg::fn_t'(func) == bspu_pkg::FN_BFM)  ? bspu_pkg::CL_BFM :
				      (bspu_pkg::fn_t'(func) == bspu_pkg::FN_UBFM) ? bspu_pkg::CL_UBFM :
				                                                     bspu_pkg::CL_SBFM;
				fx  = b_m;
				fy  = b_m;
				sh  = {1'b0, r};
			end
			bspu_pkg::FN_EXTR: begin
				cls = bspu_pkg::CL_SHIFT;
				fx  = a_m;
				fy  = b_m;
				sh  = {1'b0, r};
			end
			bspu_pkg::FN_ROR: begin
				cls = bspu_pkg::CL_SHIFT;
				fx  = a_m;
				fy  = a_m;
			end
			bspu_pkg::FN_LSLV: begin
				cls = bspu_pkg::CL_SHIFT;
				fx  = a_m;
				fy  = '0;
				sh  = (wide ? 7'd64 : 7'd32) - {1'b0, amt};
			end
			bspu_pkg::FN_LSRV: begin
				cls = bspu_pkg::CL_SHIFT;
				fx  = '0;
				fy  = a_m;
			end
			bspu_pkg::FN_ASRV: begin
				cls = bspu_pkg::CL_SHIFT;
				fx  = {64{wide ? a_m[63] : a_m[31]}};
				fy  = a_m;
			end
			bspu_pkg::FN_CLZ:   cls = bspu_pkg::CL_CLZ;
			bspu_pkg::FN_RBIT:  cls = bspu_pkg::CL_RBIT;
			bspu_pkg::FN_REV:   cls = bspu_pkg::CL_REV;
			bspu_pkg::FN_REV16: cls = bspu_pkg::CL_REV16;
			bspu_pkg::FN_REV32: cls = bspu_pkg::CL_REV32;
			default:            cls = bspu_pkg::CL_ZERO;
		endcase
	end

	// pack the decoded transaction; a 32-bit funnel lives in the low word
	assign dec.cls  = cls;
	assign dec.sh   = sh;
	assign dec.wide = wide;
	assign dec.sign = b_m[s];
	assign dec.a    = a_m;
	assign dec.hi   = wide ? fx : '0;
	assign dec.lo   = wide ? fy : {fx[31:0], fy[31:0]};
	assign dec.wm   = ones_rot[63:0] & szm;
	assign dec.tm   = ~({64{1'b1}} << ({1'b0, d} + 7'd1));

endmodule

FILE: rtl/bspu_back.sv
// ----------------------------------------------------------------------------
// bspu_back
// Execution: one funnel shifter for bitfield moves, extr, rotate and
// shifts, plus the count and permute paths, selected by operation class.
// ----------------------------------------------------------------------------
module bspu_back (
	input  bspu_pkg::dec_t        dec,
	output logic           [63:0] res
);

	logic [63:0]  szm;
	logic [127:0] fun_full;
	logic [63:0]  fun;
	logic [63:0]  bot;
	logic [63:0]  top;
	logic [63:0]  bf_res;
	logic [63:0]  rbit;
	logic [63:0]  bsw;
	logic [63:0]  clz_in;

	assign szm = dec.wide ? {64{1'b1}} : bspu_pkg::LOW_WORD;

	// funnel shift
	assign fun_full = {dec.hi, dec.lo} >> dec.sh;
	assign fun      = fun_full[63:0];

	// bitfield merge
	always_comb begin
		case (dec.cls)
			bspu_pkg::CL_BFM: begin
				bot = (dec.a & ~dec.wm) | (fun & dec.wm);
				top = dec.a;
			end
			bspu_pkg::CL_SBFM: begin
				bot = fun & dec.wm;
				top = dec.sign ? szm : '0;
			end
			default: begin
				bot = fun & dec.wm;
				top = '0;
			end
		endcase
	end
	assign bf_res = ((top & ~dec.tm) | (bot & dec.tm)) & szm;

	// permutes; a 32-bit word lands in the upper half of the 64-bit reversal
	assign rbit   = bspu_pkg::rev_bits64(dec.a);
	assign bsw    = bspu_pkg::bswap64(dec.a);
	// a marker bit below a 32-bit word caps its count at 32
	assign clz_in = dec.wide ? dec.a : {dec.a[31:0], 32'h8000_0000};

	// result select
	always_comb begin
		case (dec.cls)
			bspu_pkg::CL_BFM, bspu_pkg::CL_UBFM, bspu_pkg::CL_SBFM: res = bf_res;
			bspu_pkg::CL_SHIFT: res = fun & szm;
			bspu_pkg::CL_CLZ:   res = {57'd0, bspu_pkg::clz64(clz_in)};
			bspu_pkg::CL_RBIT:  res = dec.wide ? rbit : {32'd0, rbit[63:32]};
			bspu_pkg::CL_REV:   res = dec.wide ? bsw : {32'd0, bsw[63:32]};
			bspu_pkg::CL_REV16: res = (((dec.a << 8) & bspu_pkg::HALF_SWAP_HI) |
			                           ((dec.a >> 8) & bspu_pkg::HALF_SWAP_LO)) & szm;
			bspu_pkg::CL_REV32: res = (((dec.a << 24) & bspu_pkg::REV32_M3) |
			                           ((dec.a << 8)  & bspu_pkg::REV32_M2) |
			                           ((dec.a >> 8)  & bspu_pkg::REV32_M1) |
			                           ((dec.a >> 24) & bspu_pkg::REV32_M0)) & szm;
			default:            res = '0;
		endcase
	end

endmodule

FILE: rtl/bitfield_shift_permute_unit_core.sv
// ----------------------------------------------------------------------------
// bitfield_shift_permute_unit_core
// Bitfield move, shift, rotate, count and byte/bit permute unit, 32 or 64 bit.
// ----------------------------------------------------------------------------
// The unit takes one operation per clock and returns one result per clock
// while full and empty allow, in order, with no state carried between
// operations. An accepted operation is decoded into the operation queue,
// executed into the result queue once it is at the head and that queue has
// room, and is on the result ports once it reaches the head there. The path
// is set by the two queue stages, decode in front of the first and the funnel
// shifter with the result select in front of the second; each queue holds
// QUEUE_DEPTH transactions, so a stalled reader fills the result queue before
// full is raised toward the writer.
module bitfield_shift_permute_unit_core #(
	parameter int unsigned QUEUE_DEPTH = bspu_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [3:0]  func,
	input  logic        wide,
	input  logic [63:0] src_a,
	input  logic [63:0] src_b,
	input  logic [5:0]  rotate_field,
	input  logic [5:0]  top_field,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] result
);

	localparam int unsigned DW = $bits(bspu_pkg::dec_t);

	bspu_pkg::dec_t dec_in;
	bspu_pkg::dec_t dec_head;
	logic [DW-1:0]  dec_head_raw;
	logic           mid_empty;
	logic           mid_pop;
	logic           out_full;
	logic [63:0]    back_res;

	// decode
	bspu_front u_front (
		.func         (func),
		.wide         (wide),
		.src_a        (src_a),
		.src_b        (src_b),
		.rotate_field (rotate_field),
		.top_field    (top_field),
		.dec          (dec_in)
	);

	// decoded operation queue
	bspu_queue #(
		.WIDTH (DW),
		.DEPTH (QUEUE_DEPTH)
	) u_op_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (DW'(dec_in)),
		.full    (full),
		.pop     (mid_pop),
		.rd_data (dec_head_raw),
		.empty   (mid_empty)
	);

	assign dec_head = bspu_pkg::dec_t'(dec_head_raw);
	assign mid_pop  = !mid_empty && !out_full;

	// execute
	bspu_back u_back (
		.dec (dec_head),
		.res (back_res)
	);

	// result queue
	bspu_queue #(
		.WIDTH (64),
		.DEPTH (QUEUE_DEPTH)
	) u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (mid_pop),
		.wr_data (back_res),
		.full    (out_full),
		.pop     (pop),
		.rd_data (result),
		.empty   (empty)
	);

	// an accepted transaction is waiting for execution on the next cycle
	a_accept_reaches_back: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> !mid_empty)
		else $error("accepted transaction missing from operation queue");

	// an executed transaction is visible on the result side on the next cycle
	a_exec_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |=> !empty)
		else $error("executed transaction missing from result queue");

	// 32-bit operations never produce upper-word bits
	a_narrow_zero_ext: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop && !dec_head.wide |-> back_res[63:32] == 32'd0)
		else $error("32-bit result has nonzero upper word");

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bitfield, shift and permute unit. A directed
// table of corner operations is followed by random operations; every result
// popped is compared with its table value or a bit-exact prediction made
// here; both sides idle at random in two of the three traffic phases.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// func codes with no operation behind them
	localparam logic [3:0] FN_SPARE0 = 4'd13;
	localparam logic [3:0] FN_SPARE2 = 4'd15;

	localparam int RANDOM_OPS = 1600;

	// one operation of stimulus; want is used when fixed is set
	typedef struct packed {
		logic [3:0]  fn;
		logic        wide;
		logic [63:0] a;
		logic [63:0] b;
		logic [5:0]  immr;
		logic [5:0]  imms;
		logic        fixed;
		logic [63:0] want;
	} op_row_t;

	// directed corner cases
	localparam op_row_t DIRECTED [25] = '{
		'{bspu_pkg::FN_CLZ, 1'b1, 64'h0, 64'h0, 6'd0, 6'd0, 1'b1, 64'd64},
		'{bspu_pkg::FN_CLZ, 1'b0, 64'hFFFF_FFFF_0000_0000, 64'h0, 6'd0, 6'd0,
			1'b1, 64'd32},
		'{bspu_pkg::FN_CLZ, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 6'd0, 6'd0,
			1'b1, 64'd0},
		'{FN_SPARE0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 6'd63,
			1'b1, 64'h0},
		'{FN_SPARE2, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 6'd63, 6'd63, 1'b1, 64'h0},
		'{bspu_pkg::FN_BFM, 1'b1, 64'hFEDC_BA98_7654_3210, 64'h0123_4567_89AB_CDEF,
			6'd0, 6'd63, 1'b1, 64'h0123_4567_89AB_CDEF},
		'{bspu_pkg::FN_BFM, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_00AB,
			6'd24, 6'd7, 1'b0, 64'h0},
		'{bspu_pkg::FN_UBFM, 1'b1, 64'h0, 64'hDEAD_BEEF_CAFE_F00D, 6'd60, 6'd59,
			1'b0, 64'h0},
		'{bspu_pkg::FN_UBFM, 1'b0, 64'h0, 64'h8765_4321_F0F0_A5A5, 6'd39, 6'd63,
			1'b0, 64'h0},
		'{bspu_pkg::FN_SBFM, 1'b0, 64'h0, 64'hFFFF_FFFF_0000_0080, 6'd0, 6'd7,
			1'b1, 64'h0000_0000_FFFF_FF80},
		'{bspu_pkg::FN_SBFM, 1'b1, 64'h0, 64'h0000_0000_8000_0000, 6'd0, 6'd31,
			1'b1, 64'hFFFF_FFFF_8000_0000},
		'{bspu_pkg::FN_SBFM, 1'b1, 64'h0, 64'h8000_0000_0000_0000, 6'd63, 6'd63,
			1'b0, 64'h0},
		'{bspu_pkg::FN_EXTR, 1'b1, 64'h1111_2222_3333_4444, 64'h0123_4567_89AB_CDEF,
			6'd0, 6'd0, 1'b1, 64'h0123_4567_89AB_CDEF},
		'{bspu_pkg::FN_EXTR, 1'b0, 64'hAAAA_BBBB_CCCC_DDDD, 64'h1234_5678_8765_4321,
			6'd32, 6'd0, 1'b1, 64'h0000_0000_8765_4321},
		'{bspu_pkg::FN_ROR, 1'b1, 64'h0123_4567_89AB_CDEF, 64'd64, 6'd0, 6'd0,
			1'b1, 64'h0123_4567_89AB_CDEF},
		'{bspu_pkg::FN_ROR, 1'b0, 64'h0123_4567_89AB_CDEF, 64'd33, 6'd0, 6'd0,
			1'b0, 64'h0},
		'{bspu_pkg::FN_LSLV, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd63, 6'd0, 6'd0,
			1'b1, 64'h8000_0000_0000_0000},
		'{bspu_pkg::FN_LSRV, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd31, 6'd0, 6'd0,
			1'b1, 64'h1},
		'{bspu_pkg::FN_ASRV, 1'b1, 64'h8000_0000_0000_0000, 64'd63, 6'd0, 6'd0,
			1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
		'{bspu_pkg::FN_ASRV, 1'b0, 64'h0000_0000_8000_0000, 64'd31, 6'd0, 6'd0,
			1'b1, 64'h0000_0000_FFFF_FFFF},
		'{bspu_pkg::FN_RBIT, 1'b1, 64'h1, 64'h0, 6'd0, 6'd0,
			1'b1, 64'h8000_0000_0000_0000},
		'{bspu_pkg::FN_RBIT, 1'b0, 64'hFFFF_FFFF_0000_0001, 64'h0, 6'd0, 6'd0,
			1'b1, 64'h0000_0000_8000_0000},
		'{bspu_pkg::FN_REV, 1'b1, 64'h0102_0304_0506_0708, 64'h0, 6'd0, 6'd0,
			1'b1, 64'h0807_0605_0403_0201},
		'{bspu_pkg::FN_REV16, 1'b1, 64'h0102_0304_0506_0708, 64'h0, 6'd0, 6'd0,
			1'b1, 64'h0201_0403_0605_0807},
		'{bspu_pkg::FN_REV32, 1'b0, 64'h0102_0304_0506_0708, 64'h0, 6'd0, 6'd0,
			1'b1, 64'h0000_0000_0807_0605}
	};

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [3:0]  func;
	logic        wide;
	logic [63:0] src_a;
	logic [63:0] src_b;
	logic [5:0]  rotate_field;
	logic [5:0]  top_field;
	logic        empty;
	logic        pop = 1'b0;
	logic [63:0] result;

	logic [63:0] pending_results [$];
	logic [63:0] oldest_result;
	int          mismatch_count = 0;
	int unsigned src_idle_pct   = 6;
	int unsigned sink_idle_pct  = 83;

	bitfield_shift_permute_unit_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.func         (func),
		.wide         (wide),
		.src_a        (src_a),
		.src_b        (src_b),
		.rotate_field (rotate_field),
		.top_field    (top_field),
		.empty        (empty),
		.pop          (pop),
		.result       (result)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// rotate right within the datasize
	function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned r,
		input int unsigned w);
		logic [63:0] m;
		int unsigned k;
		m = (w == 64) ? '1 : bspu_pkg::LOW_WORD;
		k = r & (w - 1);
		if (k == 0) begin
			return x & m;
		end
		return ((x >> k) | (x << (w - k))) & m;
	endfunction

	// n low bits set, all ones from 64 up
	function automatic logic [63:0] low_ones(input int unsigned n);
		if (n >= 64) begin
			return '1;
		end
		return (64'd1 << n) - 64'd1;
	endfunction

	// predicted result of one operation
	function automatic logic [63:0] permute_result(input op_row_t op);
		int unsigned w, lv, s, r, d, amt, nb;
		logic [63:0] m, a, b, wmask, tmask, bot, top, res;
		w = op.wide ? 64 : 32;
		lv = w - 1;
		m = op.wide ? '1 : bspu_pkg::LOW_WORD;
		a = op.a & m;
		b = op.b & m;
		s = op.imms & lv;
		r = op.immr & lv;
		d = (s - r) & lv;
		amt = b[5:0];
		amt = amt & lv;
		nb = w / 8;
		res = '0;
		case (op.fn)
			bspu_pkg::FN_BFM, bspu_pkg::FN_UBFM, bspu_pkg::FN_SBFM: begin
				wmask = rotr(low_ones(s + 1), r, w);
				tmask = low_ones(d + 1);
				bot = rotr(b, r, w) & wmask;
				top = '0;
				if (op.fn == bspu_pkg::FN_BFM) begin
					bot = (a & ~wmask) | bot;
					top = a;
				end else if (op.fn == bspu_pkg::FN_SBFM && b[s]) begin
					top = m;
				end
				res = (top & ~tmask) | (bot & tmask);
			end
			bspu_pkg::FN_EXTR: begin
				if (r == 0) begin
					res = b;
				end else begin
					res = (b >> r) | (a << (w - r));
				end
			end
			bspu_pkg::FN_ROR: res = rotr(a, amt, w);
			bspu_pkg::FN_LSLV: res = a << amt;
			bspu_pkg::FN_LSRV: res = a >> amt;
			bspu_pkg::FN_ASRV: begin
				res = a >> amt;
				if (amt != 0 && a[lv]) begin
					res = res | (m & ~(m >> amt));
				end
			end
			bspu_pkg::FN_CLZ: begin
				// highest set bit wins
				res = 64'(w);
				for (int i = 0; i < w; i++) begin
					if (a[i]) begin
						res = 64'(w - 1 - i);
					end
				end
			end
			bspu_pkg::FN_RBIT: begin
				for (int i = 0; i < w; i++) begin
					res[lv - i] = a[i];
				end
			end
			bspu_pkg::FN_REV: begin
				for (int i = 0; i < nb; i++) begin
					res[8 * (nb - 1 - i) +: 8] = a[8 * i +: 8];
				end
			end
			bspu_pkg::FN_REV16: begin
				res = ((a << 8) & bspu_pkg::HALF_SWAP_HI) |
					((a >> 8) & bspu_pkg::HALF_SWAP_LO);
			end
			bspu_pkg::FN_REV32: begin
				res = ((a << 24) & bspu_pkg::REV32_M3) | ((a << 8) & bspu_pkg::REV32_M2) |
					((a >> 8) & bspu_pkg::REV32_M1) | ((a >> 24) & bspu_pkg::REV32_M0);
			end
			default: res = '0;
		endcase
		return res & m;
	endfunction

	// operand with a bias toward edge patterns
	function automatic logic [63:0] pick_operand();
		logic [63:0] one_hot;
		one_hot = 64'd1 << $urandom_range(63, 0);
		case ($urandom_range(7, 0))
			0: return '0;
			1: return '1;
			2: return one_hot;
			3: return ~one_hot;
			4: return 64'($urandom_range(127, 0));
			5: return {32'($urandom), 1'b1, 31'($urandom)};
			default: return {32'($urandom), 32'($urandom)};
		endcase
	endfunction

	// random operation, spare codes now and then
	function automatic op_row_t random_op();
		op_row_t op;
		op = '0;
		if ($urandom_range(15, 0) == 0) begin
			op.fn = 4'($urandom_range(FN_SPARE2, FN_SPARE0));
		end else begin
			op.fn = 4'($urandom_range(bspu_pkg::FN_REV32, bspu_pkg::FN_BFM));
		end
		op.wide = 1'($urandom_range(1, 0));
		op.a = pick_operand();
		op.b = pick_operand();
		op.immr = 6'($urandom_range(63, 0));
		op.imms = 6'($urandom_range(63, 0));
		return op;
	endfunction

	// push one transaction; starts and ends at a falling edge
	task automatic send_op(input op_row_t op);
		while ($urandom_range(99, 0) < src_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		func <= op.fn;
		wide <= op.wide;
		src_a <= op.a;
		src_b <= op.b;
		rotate_field <= op.immr;
		top_field <= op.imms;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		pending_results.push_back(op.fixed ? op.want : permute_result(op));
		@(negedge clk);
	endtask

	// receiver stalls
	always @(negedge clk) begin
		pop <= ($urandom_range(99, 0) >= sink_idle_pct);
	end

	// result checking
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				$error("result: no transaction pending, actual %h", result);
			end else begin
				oldest_result = pending_results.pop_front();
				if (result !== oldest_result) begin
					mismatch_count++;
					$error("result: expected %h, actual %h", oldest_result, result);
				end
			end
		end
	end

	// stimulus
	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		func = bspu_pkg::FN_BFM;
		wide = 1'b0;
		src_a = '0;
		src_b = '0;
		rotate_field = '0;
		top_field = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED[i]) begin
			send_op(DIRECTED[i]);
		end

		// three traffic phases
		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (n == RANDOM_OPS / 3) begin
				src_idle_pct = 83;
				sink_idle_pct = 6;
			end else if (n == 2 * RANDOM_OPS / 3) begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end
			send_op(random_op());
		end
		push <= 1'b0;

		// drain, then watch for stray results
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#3_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/bspu_pkg.sv
rtl/bspu_queue.sv
rtl/bspu_front.sv
rtl/bspu_back.sv
rtl/bitfield_shift_permute_unit_core.sv
tb/tb.sv
